// ===== rtl/pdl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdl_pkg - shared types for the positional insert/delete list
// Request and status codes, the entry word, the per-cell command and the result.
// ---------------------------------------------------------------------------
package pdl_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_RETRIEVE = 3'd2,
    KIND_REPLACE  = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  // Broadcast command to every cell of the row
  typedef struct packed {
    logic ins;   // open a gap at pos and write the value there
    logic del;   // close the gap at pos
    logic wr;    // overwrite the entry at pos
  } cell_cmd_t;

  // One result transaction
  typedef struct packed {
    word_t                value;
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 full;
    logic                 empty;
  } result_t;

endpackage

// ===== rtl/pdl_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdl_cell - one list slot
// Holds one entry, takes its left or right neighbour on a shift, and adds
// its entry to the registered read chain when the read position is its own.
// ---------------------------------------------------------------------------
module pdl_cell #(
  parameter int unsigned CMPW = 9,
  parameter int unsigned IDX  = 0
) (
  input  logic              clk,
  input  pdl_pkg::cell_cmd_t cmd,
  input  logic [CMPW-1:0]   pos,
  input  logic [CMPW-1:0]   held,
  input  pdl_pkg::word_t    value,
  input  pdl_pkg::word_t    left,
  input  pdl_pkg::word_t    right,
  input  pdl_pkg::word_t    bus_in,
  output pdl_pkg::word_t    bus_out,
  output pdl_pkg::word_t    entry
);
  import pdl_pkg::*;

  localparam logic [CMPW-1:0] MY_IDX  = CMPW'(IDX);
  localparam logic [CMPW-1:0] NXT_IDX = CMPW'(IDX + 1);

  logic take_value;
  logic take_left;
  logic take_right;
  logic at_pos;

  // Local decode of the broadcast command
  assign at_pos     = (pos == MY_IDX);
  assign take_value = (cmd.ins || cmd.wr) && at_pos;
  assign take_left  = cmd.ins && (MY_IDX > pos) && (MY_IDX <= held);
  assign take_right = cmd.del && (MY_IDX >= pos) && (NXT_IDX < held);

  // Entry register
  always_ff @(posedge clk) begin
    if (take_value) begin
      entry <= value;
    end else if (take_left) begin
      entry <= left;
    end else if (take_right) begin
      entry <= right;
    end
  end

  // Read chain stage
  always_ff @(posedge clk) begin
    bus_out <= bus_in | (at_pos ? entry : word_t'(0));
  end

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_insert_delete_list - ordered list with positional shifts
// Row of CAPACITY cells holding the list, a read chain through the cells
// and a two-deep result queue.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with kind, position and value_in;
//   a request transaction completes when in_valid is high and in_stall low.
//   Every request gives exactly one result on out_valid/out_stall carrying
//   value_out, status, count, is_full and is_empty.
//   Insert, replace, clear, flagged requests and unused kinds act in the
//   cycle of acceptance, which also pushes their result into the queue.
//   An accepted delete or retrieve reads its entry through the registered
//   read chain that runs through every cell, one cell per cycle, and its
//   result is pushed when the read is done; a delete closes the gap in
//   that same cycle. One request is worked on at a time.
//   A two-deep result queue lets the next request be taken while an earlier
//   result waits; in_stall rises while a read is in flight or the queue is
//   full, so a stalled receiver eventually holds off new requests.
//   Reset (rst, synchronous) empties the list count and the result queue;
//   entry contents are left as they are.
// ---------------------------------------------------------------------------
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pdl_pkg::KIND_W-1:0]       kind,
  input  logic [pdl_pkg::POS_W-1:0]        position,
  input  logic signed [pdl_pkg::WORD_W-1:0] value_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pdl_pkg::WORD_W-1:0] value_out,
  output logic [pdl_pkg::STATUS_W-1:0]     status,
  output logic [pdl_pkg::COUNT_W-1:0]      count,
  output logic                             is_full,
  output logic                             is_empty
);
  import pdl_pkg::*;

  localparam int unsigned HW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (HW > POS_W) ? HW : POS_W;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);
  localparam logic [HW-1:0]   CNT_START = HW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t            state;
  logic [HW-1:0]     held;
  logic [HW-1:0]     held_next;
  logic [HW-1:0]     wait_cnt;
  logic [CMPW-1:0]   pos_q;
  logic              del_q;

  // Result queue: head and one spare slot
  result_t           q_head;
  result_t           q_tail;
  logic              q_head_v;
  logic              q_tail_v;

  logic              accept;
  logic              pop;
  logic              push;
  logic              read_done;
  logic              start_read;
  result_t           push_res;
  status_t           chk_status;
  logic [CMPW-1:0]   held_ext;
  logic [CMPW-1:0]   held_next_ext;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   cell_pos;
  cell_cmd_t         cmd;

  word_t             entry [CAPACITY];
  word_t             bus   [CAPACITY+1];

  assign accept    = in_valid && !in_stall;
  assign pop       = q_head_v && !out_stall;
  assign in_stall  = (state != S_IDLE) || q_tail_v;
  assign read_done = (state == S_READ) && (wait_cnt == '0);
  assign held_ext  = CMPW'(held);
  assign pos_ext   = CMPW'(position);
  assign cell_pos  = (state == S_READ) ? pos_q : pos_ext;

  // Precondition checks on the incoming request
  always_comb begin
    chk_status = STATUS_OK;
    case (kind)
      KIND_INSERT: begin
        if (held_ext >= CAP_C) begin
          chk_status = STATUS_FULL;
        end else if (pos_ext > held_ext) begin
          chk_status = STATUS_RANGE;
        end
      end
      KIND_DELETE, KIND_RETRIEVE, KIND_REPLACE: begin
        if (held == '0) begin
          chk_status = STATUS_EMPTY;
        end else if (pos_ext >= held_ext) begin
          chk_status = STATUS_RANGE;
        end
      end
      default: chk_status = STATUS_OK;
    endcase
  end

  // Command to the cells, count update and result to queue
  always_comb begin
    cmd        = '0;
    held_next  = held;
    push       = 1'b0;
    start_read = 1'b0;
    push_res.value = word_t'(0);
    push_res.status = STATUS_OK;
    if (read_done) begin
      push           = 1'b1;
      push_res.value = bus[CAPACITY];
      if (del_q) begin
        cmd.del   = 1'b1;
        held_next = held - HW'(1);
      end
    end else if (accept) begin
      push_res.status = chk_status;
      push            = 1'b1;
      if (chk_status == STATUS_OK) begin
        case (kind)
          KIND_INSERT: begin
            cmd.ins   = 1'b1;
            held_next = held + HW'(1);
          end
          KIND_REPLACE: cmd.wr = 1'b1;
          KIND_CLEAR:   held_next = '0;
          KIND_DELETE, KIND_RETRIEVE: begin
            push       = 1'b0;
            start_read = 1'b1;
          end
          default: held_next = held;
        endcase
      end
    end
    held_next_ext  = CMPW'(held_next);
    push_res.count = held_next_ext[COUNT_W-1:0];
    push_res.full  = (held_next_ext == CAP_C);
    push_res.empty = (held_next == '0);
  end

  // Row of cells with the read chain from the first cell to the last
  assign bus[0] = word_t'(0);
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = word_t'(0);
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = word_t'(0);
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end
    pdl_cell #(
      .CMPW (CMPW),
      .IDX  (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (cell_pos),
      .held    (held_ext),
      .value   (value_in),
      .left    (left_w),
      .right   (right_w),
      .bus_in  (bus[i]),
      .bus_out (bus[i+1]),
      .entry   (entry[i])
    );
  end

  // Control state, count and result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      wait_cnt <= '0;
      q_head_v <= 1'b0;
      q_tail_v <= 1'b0;
    end else begin
      held <= held_next;
      case (state)
        S_IDLE: begin
          if (start_read) begin
            state    <= S_READ;
            wait_cnt <= CNT_START;
          end
        end
        S_READ: begin
          if (read_done) begin
            state <= S_IDLE;
          end else begin
            wait_cnt <= wait_cnt - HW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase

      case ({pop, push})
        2'b11: begin
          if (q_tail_v) begin
            q_head <= q_tail;
            q_tail <= push_res;
          end else begin
            q_head <= push_res;
          end
        end
        2'b10: begin
          q_head   <= q_tail;
          q_head_v <= q_tail_v;
          q_tail_v <= 1'b0;
        end
        2'b01: begin
          if (!q_head_v) begin
            q_head   <= push_res;
            q_head_v <= 1'b1;
          end else begin
            q_tail   <= push_res;
            q_tail_v <= 1'b1;
          end
        end
        default: begin
          q_head_v <= q_head_v;
        end
      endcase
    end
  end

  // Request capture for the read phase
  always_ff @(posedge clk) begin
    if (start_read) begin
      pos_q <= pos_ext;
      del_q <= (kind == KIND_DELETE);
    end
  end

  assign out_valid = q_head_v;
  assign value_out = q_head.value;
  assign status    = q_head.status;
  assign count     = q_head.count;
  assign is_full   = q_head.full;
  assign is_empty  = q_head.empty;

endmodule
